/* rtl/count_vector_rank_index_unit_macros.svh */
// assertion macros shared by the rank index unit modules
`ifndef COUNT_VECTOR_RANK_INDEX_UNIT_MACROS_SVH
`define COUNT_VECTOR_RANK_INDEX_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CVRI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CVRI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cvri_pkg.sv */
// package with widths, register codes and control structs of the rank index unit
`timescale 1ns / 1ps

package cvri_pkg;

    localparam int MAX_STATES_DEF     = 8;
    localparam int MAX_NEIGHBOURS_DEF = 32;

    localparam int VALUE_W    = 27;
    localparam int OWN_W      = 3;
    localparam int COUNT_W    = 6;
    localparam int NUM_COUNTS = 7;

    localparam int STATES_CFG_W = 4;
    localparam int NEIGHB_CFG_W = 6;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_ADDR_W   = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_STATES      = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEIGHBOUR_COUNT = 1'b1;

    localparam int IN_DATA_W  = ((OWN_W + NUM_COUNTS * COUNT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * VALUE_W + 7) / 8) * 8;

    // controller to datapath
    typedef struct packed {
        logic fill_step;
        logic load;
        logic check;
        logic latch_block;
        logic step;
        logic finish;
    } cvri_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_done;
        logic bad;
        logic last_digit;
        logic out_free;
    } cvri_sts_t;

endpackage

/* rtl/cvri_ram.sv */
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps

module cvri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

/* rtl/cvri_controller.sv */
// sequencing state machine of the rank index unit
`timescale 1ns / 1ps
`include "count_vector_rank_index_unit_macros.svh"

module cvri_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cvri_pkg::cvri_sts_t sts,
    output cvri_pkg::cvri_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_CHECK,
        ST_BLOCK,
        ST_DIGIT,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        in_ready_next = 1'b0;
        unique case (state_reg)
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_done)
                begin
                    state_next    = ST_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_ready_next = 1'b1;
                if (in_valid && in_ready_reg)
                begin
                    cmd.load      = 1'b1;
                    state_next    = ST_CHECK;
                    in_ready_next = 1'b0;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_BLOCK;
            end
            ST_BLOCK:
            begin
                cmd.latch_block = 1'b1;
                state_next      = sts.bad ? ST_FINISH : ST_DIGIT;
            end
            ST_DIGIT:
            begin
                cmd.step = 1'b1;
                if (sts.last_digit)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish    = 1'b1;
                    state_next    = ST_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

    `CVRI_ASSERT_SAME(a_ready_only_idle, in_ready_reg, state_reg == ST_IDLE, "ready outside idle")
    `CVRI_ASSERT_NEXT(a_bad_skips_digits, state_reg == ST_BLOCK && sts.bad, state_reg == ST_FINISH, "bad request entered digit loop")

endmodule

/* rtl/cvri_datapath.sv */
// datapath: config registers, binomial table fill, digit ranking and output register
`timescale 1ns / 1ps
`include "count_vector_rank_index_unit_macros.svh"

module cvri_datapath #(
    parameter int MAX_STATES     = cvri_pkg::MAX_STATES_DEF,
    parameter int MAX_NEIGHBOURS = cvri_pkg::MAX_NEIGHBOURS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cvri_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [cvri_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [cvri_pkg::IN_DATA_W-1:0]    in_data,
    output logic [cvri_pkg::OUT_DATA_W-1:0]   out_data,
    output logic                              out_bad,
    output logic                              out_valid,
    input  logic                              out_ready,
    input  cvri_pkg::cvri_cmd_t               cmd,
    output cvri_pkg::cvri_sts_t               sts
);

    localparam int VW     = cvri_pkg::VALUE_W;
    localparam int COLS   = 2 ** $clog2(MAX_STATES);
    localparam int CW     = $clog2(COLS);
    localparam int SW     = CW + 1;
    localparam int NW     = $clog2(MAX_NEIGHBOURS + 1);
    localparam int ADDR_W = NW + CW;
    localparam int DEPTH  = (MAX_NEIGHBOURS + 1) * COLS;
    localparam int NC     = cvri_pkg::NUM_COUNTS;
    localparam int CNT_W  = cvri_pkg::COUNT_W;
    localparam int SUM_W  = CNT_W + $clog2(NC + 1);
    localparam int DIFF_W = ((NW > CNT_W) ? NW : CNT_W) + 1;
    localparam int PAD_W  = cvri_pkg::OUT_DATA_W - 2 * VW;

    // configuration
    logic [cvri_pkg::STATES_CFG_W-1:0] num_states_reg;
    logic [cvri_pkg::NEIGHB_CFG_W-1:0] neighbour_count_reg;
    logic [SW-1:0]                     s_eff;
    logic [NW-1:0]                     n_eff;
    logic [CW-1:0]                     digits;

    // table fill
    logic [NW-1:0] fill_n_reg;
    logic [CW-1:0] fill_m_reg;
    logic [VW-1:0] fill_acc_reg;
    logic [VW-1:0] row_reg [COLS];
    logic [VW-1:0] fill_val;

    // item work
    logic [cvri_pkg::OWN_W-1:0] own_reg;
    logic [CNT_W-1:0]           cnt_reg [NC];
    logic [NW-1:0]              rem_reg;
    logic [NW-1:0]              rem_after;
    logic [CW-1:0]              col_reg;
    logic [VW-1:0]              rank_reg;
    logic [VW-1:0]              block_reg;
    logic                       bad_reg;
    logic                       bad_now;
    logic                       pend_reg;
    logic [SUM_W-1:0]           sum;

    // output register
    logic [VW-1:0] out_index_reg;
    logic [VW-1:0] out_size_reg;
    logic          out_bad_reg;
    logic          out_valid_reg;

    // ram ports
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [VW-1:0]     rd_data_a;
    logic [VW-1:0]     rd_data_b;

    always_comb
    begin
        if (num_states_reg < cvri_pkg::STATES_CFG_W'(2))
        begin
            s_eff = SW'(2);
        end
        else if (int'(num_states_reg) > MAX_STATES)
        begin
            s_eff = SW'(MAX_STATES);
        end
        else
        begin
            s_eff = SW'(num_states_reg);
        end
        if (int'(neighbour_count_reg) > MAX_NEIGHBOURS)
        begin
            n_eff = NW'(MAX_NEIGHBOURS);
        end
        else
        begin
            n_eff = NW'(neighbour_count_reg);
        end
    end

    assign digits = CW'(s_eff - SW'(1));

    // W(n,m) = W(n-1,m) + W(n,m-1), row by row
    assign fill_val = (fill_n_reg == '0 || fill_m_reg == '0) ? VW'(1)
                                                             : fill_acc_reg + row_reg[fill_m_reg];

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NC; i++)
        begin
            if (i < int'(digits))
            begin
                sum = sum + SUM_W'(cnt_reg[i]);
            end
        end
        bad_now = (int'(own_reg) >= int'(s_eff)) || (sum > SUM_W'(n_eff));
    end

    assign rem_after = NW'(DIFF_W'(rem_reg) - DIFF_W'(cnt_reg[0]));
    assign rd_addr_a = cmd.check ? {n_eff, digits} : {rem_reg, col_reg};
    assign rd_addr_b = {rem_after, col_reg};

    cvri_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk       (clk),
        .wr_en     (cmd.fill_step),
        .wr_addr   ({fill_n_reg, fill_m_reg}),
        .wr_data   (fill_val),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg      <= cvri_pkg::STATES_CFG_W'(2);
            neighbour_count_reg <= cvri_pkg::NEIGHB_CFG_W'(8);
            fill_n_reg          <= '0;
            fill_m_reg          <= '0;
            pend_reg            <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    cvri_pkg::CFG_NUM_STATES:
                    begin
                        num_states_reg <= cfg_wdata[cvri_pkg::STATES_CFG_W-1:0];
                    end
                    cvri_pkg::CFG_NEIGHBOUR_COUNT:
                    begin
                        neighbour_count_reg <= cfg_wdata[cvri_pkg::NEIGHB_CFG_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.fill_step)
            begin
                fill_m_reg <= fill_m_reg + CW'(1);
                if (fill_m_reg == CW'(COLS - 1))
                begin
                    fill_n_reg <= fill_n_reg + NW'(1);
                end
            end
            pend_reg <= cmd.step;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_step)
        begin
            row_reg[fill_m_reg] <= fill_val;
            fill_acc_reg        <= fill_val;
        end
        if (cmd.load)
        begin
            own_reg <= in_data[cvri_pkg::OWN_W-1:0];
            for (int i = 0; i < NC; i++)
            begin
                cnt_reg[i] <= in_data[cvri_pkg::OWN_W + i * CNT_W +: CNT_W];
            end
        end
        else if (cmd.step)
        begin
            for (int i = 0; i < NC - 1; i++)
            begin
                cnt_reg[i] <= cnt_reg[i + 1];
            end
            cnt_reg[NC - 1] <= '0;
        end
        if (cmd.check)
        begin
            bad_reg <= bad_now;
            rem_reg <= n_eff;
            col_reg <= digits;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_after;
            col_reg <= col_reg - CW'(1);
        end
        if (cmd.latch_block)
        begin
            block_reg <= rd_data_a;
        end
        // digit term is W(rem, col) - W(rem - count, col)
        if (cmd.check)
        begin
            rank_reg <= '0;
        end
        else if (pend_reg)
        begin
            rank_reg <= rank_reg + rd_data_a - rd_data_b;
        end
        if (cmd.finish)
        begin
            out_index_reg <= bad_reg ? '0 : VW'(block_reg * VW'(own_reg)) + rank_reg;
            out_size_reg  <= VW'(block_reg * VW'(s_eff));
            out_bad_reg   <= bad_reg;
        end
    end

    assign sts.fill_done  = (fill_n_reg == NW'(MAX_NEIGHBOURS)) && (fill_m_reg == CW'(COLS - 1));
    assign sts.bad        = bad_reg;
    assign sts.last_digit = (col_reg == CW'(1));
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_data  = {{PAD_W{1'b0}}, out_size_reg, out_index_reg};
    assign out_bad   = out_bad_reg;
    assign out_valid = out_valid_reg;

    `CVRI_ASSERT_SAME(a_bad_zero_index, out_valid_reg && out_bad_reg, out_index_reg == '0, "bad result with nonzero index")
    `CVRI_ASSERT_SAME(a_step_col_live, cmd.step, !bad_reg && col_reg != '0, "digit step on bad item or past last digit")
    `CVRI_ASSERT_SAME(a_finish_drained, cmd.finish, !pend_reg, "result taken before last digit summed")

endmodule

/* rtl/count_vector_rank_index_unit.sv */
// top level of the count vector rank index unit
//
//  channel  | direction | handshake                 | contents
//  ---------+-----------+---------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid/tready      | own state and seven neighbour counts
//  m_axis   | out       | m_axis_tvalid/tready      | table index, table size, bad flag
//  cfg      | in        | cfg_we (no wait)          | num_states, neighbour_count
//
// a good request runs check, block read, the digit loop, drain and finish before the next
// ready, a bad one skips the digit loop and drain; the loop does one dual-read table access per used count digit
// after reset the binomial table of (MAX_NEIGHBOURS+1)*2**clog2(MAX_STATES) entries (264 by default)
// is built with s_axis_tready low; config writes are taken meanwhile
// the result sits in an output register, so a stalled m_axis only holds the unit
// once the next result is ready and the register is still full
`timescale 1ns / 1ps

module count_vector_rank_index_unit #(
    parameter int MAX_STATES     = cvri_pkg::MAX_STATES_DEF,
    parameter int MAX_NEIGHBOURS = cvri_pkg::MAX_NEIGHBOURS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write port
    input  logic                            cfg_we,
    input  logic [cvri_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cvri_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // own_state[2:0], count_a..count_g 6 bits each from bit 3 up, zero pad
    input  logic [cvri_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // table_index[26:0], table_size[53:27], zero pad
    output logic [cvri_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // bad_input
    output logic                            m_axis_tuser
);

    cvri_pkg::cvri_cmd_t cmd;
    cvri_pkg::cvri_sts_t sts;

    // sequencing: fill pass, accept, check, block read, digit loop, drain, finish
    cvri_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table, rank accumulator and output register
    cvri_datapath #(
        .MAX_STATES     (MAX_STATES),
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .out_bad   (m_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* bench/rank_index_checker.sv */
// checker that predicts and compares the results of the rank index unit
`timescale 1ns / 1ps

module rank_index_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cvri_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cvri_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [cvri_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [cvri_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            m_axis_tuser,
    output int                              errors,
    output int                              pending,
    output int                              results_seen,
    output int                              bad_seen
);
    import cvri_pkg::*;

    localparam int MAXS = MAX_STATES_DEF;
    localparam int MAXN = MAX_NEIGHBOURS_DEF;

    typedef struct packed {
        logic [VALUE_W-1:0] tbl_index;
        logic [VALUE_W-1:0] tbl_size;
        logic               bad;
    } rank_result_t;

    longint unsigned   binom_w [0:MAXN][0:MAXS-1];
    logic [STATES_CFG_W-1:0] states_reg;
    logic [NEIGHB_CFG_W-1:0] neigh_reg;
    rank_result_t      expected_ranks [$];
    int                requests_seen;

    // W(n,m) = C(n+m,m) by pascal recurrence
    initial
    begin
        for (int n = 0; n <= MAXN; n++)
            for (int m = 0; m < MAXS; m++)
                binom_w[n][m] = (n == 0 || m == 0) ? 1 : binom_w[n-1][m] + binom_w[n][m-1];
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            states_reg <= 4'd2;
            neigh_reg  <= 6'd8;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_NUM_STATES)
                states_reg <= cfg_wdata[STATES_CFG_W-1:0];
            else if (cfg_addr == CFG_NEIGHBOUR_COUNT)
                neigh_reg <= cfg_wdata[NEIGHB_CFG_W-1:0];
        end
    end

    function automatic rank_result_t predict_rank_entry(logic [IN_DATA_W-1:0] req);
        longint unsigned s, n, digits, block, rank, rem, sum, own, cnt;
        rank_result_t    r;
        s      = (states_reg < 2) ? 2 : (states_reg > MAXS) ? MAXS : states_reg;
        n      = (neigh_reg > MAXN) ? MAXN : neigh_reg;
        digits = s - 1;
        block  = binom_w[n][digits];
        own    = req[OWN_W-1:0];
        sum    = 0;
        for (int i = 0; i < digits; i++)
            sum += req[OWN_W + COUNT_W*i +: COUNT_W];
        r.bad      = (own >= s) || (sum > n);
        r.tbl_size = VALUE_W'(s * block);
        rank = 0;
        rem  = n;
        if (!r.bad)
        begin
            // each count value below the digit skips the block of vectors under it
            for (int i = 0; i < digits; i++)
            begin
                cnt = req[OWN_W + COUNT_W*i +: COUNT_W];
                for (int v = 0; v < cnt; v++)
                    rank += binom_w[rem - v][digits - i - 1];
                rem -= cnt;
            end
            r.tbl_index = VALUE_W'(own * block + rank);
        end
        else
            r.tbl_index = '0;
        return r;
    endfunction

    initial
    begin
        errors        = 0;
        requests_seen = 0;
        results_seen  = 0;
        bad_seen      = 0;
    end

    assign pending = requests_seen - results_seen;

    always @(posedge clk)
    begin
        rank_result_t want, got;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.tbl_index = m_axis_tdata[VALUE_W-1:0];
            got.tbl_size  = m_axis_tdata[2*VALUE_W-1:VALUE_W];
            got.bad       = m_axis_tuser;
            if (expected_ranks.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing pending: index %0d size %0d bad %0b",
                         $time, got.tbl_index, got.tbl_size, got.bad);
            end
            else
            begin
                want = expected_ranks.pop_front();
                results_seen++;
                if (got.bad)
                    bad_seen++;
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: mismatch index exp %0d got %0d, size exp %0d got %0d,",
                             $time, want.tbl_index, got.tbl_index, want.tbl_size,
                             got.tbl_size);
                    $display("%0t:   bad exp %0b got %0b", $time, want.bad, got.bad);
                end
            end
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_ranks.push_back(predict_rank_entry(s_axis_tdata));
            requests_seen++;
        end
    end

endmodule

/* bench/tb_top.sv */
// top of the rank index unit testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import cvri_pkg::*;

    // no-handshake cycles before the run is declared hung; covers the table
    // build after reset and the long receiver hold-off with margin
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 185;
    localparam int NUM_PHASES     = 9;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_NUM_STATES;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    int errors, pending, results_seen, bad_seen;

    // idling knobs, percent of cycles
    int idle_pct = 0;
    int stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int hold_cnt = 0;

    // raw register values as last written, used to shape the stimulus
    int cur_states = 2;
    int cur_neigh = 8;
    int settings_used = 1;
    int requests_sent = 0;
    int quiet_cycles = 0;

    count_vector_rank_index_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rank_index_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending),
        .results_seen  (results_seen),
        .bad_seen      (bad_seen)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side: random per-cycle stalls, plus one long hold-off counted here
    // so the unit fills its output register and backs up onto the request side
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken    <= 1'b1;
            hold_cnt      <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt      <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // offer one request, with random idle cycles ahead of it; valid stays high
    // after acceptance so back-to-back requests need no extra edge
    task automatic push_request(input logic [IN_DATA_W-1:0] req);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic send_cells(input logic [2:0] own, input logic [5:0] a, b, c, d, e, f, g);
        push_request(IN_DATA_W'({g, f, e, d, c, b, a, own}));
    endtask

    // drop valid and let the unit drain before touching registers
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_config(input int states, input int neigh);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_NUM_STATES;
        cfg_wdata <= CFG_DATA_W'(states);
        @(posedge clk);
        cfg_addr  <= CFG_NEIGHBOUR_COUNT;
        cfg_wdata <= CFG_DATA_W'(neigh);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_states = states;
        cur_neigh  = neigh;
        settings_used++;
    endtask

    // mostly count vectors that fit within N so the rank loop runs deep;
    // the rest is noise that tends to trip the bad-input path
    function automatic logic [IN_DATA_W-1:0] random_request(input bit well_formed);
        int s, n, digits, rem, start, pos, c;
        logic [2:0]  own;
        logic [41:0] cnts;
        s      = (cur_states < 2) ? 2 : (cur_states > MAX_STATES_DEF) ? MAX_STATES_DEF
                                                                      : cur_states;
        n      = (cur_neigh > MAX_NEIGHBOURS_DEF) ? MAX_NEIGHBOURS_DEF : cur_neigh;
        digits = s - 1;
        for (int i = 0; i < NUM_COUNTS; i++)
            cnts[COUNT_W*i +: COUNT_W] = COUNT_W'($urandom_range(0, 32));
        if (well_formed)
        begin
            own   = ($urandom_range(0, 9) == 0) ? OWN_W'($urandom_range(0, 7))
                                                : OWN_W'($urandom_range(0, s - 1));
            rem   = ($urandom_range(0, 2) == 0) ? n : $urandom_range(0, n);
            start = $urandom_range(0, digits - 1);
            for (int k = 0; k < digits; k++)
            begin
                pos = (start + k) % digits;
                c   = (k == digits - 1 && $urandom_range(0, 1)) ? rem : $urandom_range(0, rem);
                cnts[COUNT_W*pos +: COUNT_W] = COUNT_W'(c);
                rem -= c;
            end
        end
        else
        begin
            own = OWN_W'($urandom_range(0, 7));
            if ($urandom_range(0, 1))
                for (int i = 0; i < NUM_COUNTS; i++)
                    cnts[COUNT_W*i +: COUNT_W] = COUNT_W'($urandom_range(0, n / 2 + 1));
        end
        return IN_DATA_W'({cnts, own});
    endfunction

    initial
    begin
        int settings_s [NUM_PHASES];
        int settings_n [NUM_PHASES];
        settings_s = '{8, 2, 5, 15, 3, 1, 7, 0, 4};
        settings_n = '{32, 1, 10, 63, 0, 20, 32, 33, 6};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: S=2, N=8, only count_a matters
        send_cells(3'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
        send_cells(3'd1, 6'd8, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32);
        send_cells(3'd1, 6'd9, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
        send_cells(3'd2, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
        send_cells(3'd7, 6'd3, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
        drain();

        // widest table: all seven digits, N=32
        write_config(8, 32);
        send_cells(3'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
        send_cells(3'd7, 6'd32, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
        send_cells(3'd7, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd32);
        send_cells(3'd3, 6'd5, 6'd5, 6'd5, 6'd5, 6'd4, 6'd4, 6'd4);
        send_cells(3'd3, 6'd5, 6'd5, 6'd5, 6'd5, 6'd4, 6'd4, 6'd5);
        send_cells(3'd7, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32);
        send_cells(3'd6, 6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd0, 6'd1);
        send_cells(3'd4, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd31, 6'd1);
        send_cells(3'd5, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1);
        send_cells(3'd2, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd33);
        drain();

        // random phases: each register setting with one of four idling modes in turn,
        // including out-of-range S and N that the unit must clamp
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_config(settings_s[ph], settings_n[ph]);
            case (ph % 4)
                0: begin idle_pct <= 0;  stall_pct <= 0;  end
                1: begin idle_pct <= 69; stall_pct <= 0;  end
                2: begin idle_pct <= 0;  stall_pct <= 69; end
                default: begin idle_pct <= 26; stall_pct <= 26; end
            endcase
            if (ph == 6)
                hold_req <= 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                push_request(random_request($urandom_range(0, 99) < 80));
            drain();
        end

        $display("covered %0d requests over %0d register settings", requests_sent, settings_used);
        $display("%0d results checked, %0d of them flagged bad input", results_seen, bad_seen);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
